// ----- rtl/icp_pkg.sv -----
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants for the tolerant incircle predicate pipeline.
// ----------------------------------------------------------------------------
package icp_pkg;

	// Default coordinate width in grid bits.
	localparam int COORD_WIDTH_DEF = 16;

	// Width of the tolerance multiplier and its value after reset.
	localparam int                   SCALE_W     = 16;
	localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd1181;

	// The tolerance is (m^4 * scale) shifted right by this many bits.
	localparam int TOL_SHIFT = 70;

	// Result codes.
	typedef enum logic [1:0] {
		SIDE_OUTSIDE = 2'd0,
		SIDE_ON      = 2'd1,
		SIDE_INSIDE  = 2'd2
	} side_t;

endpackage

// ----- rtl/incircle_predicate_tolerant.sv -----
// ----------------------------------------------------------------------------
// incircle_predicate_tolerant
// Eight-stage pipeline that classifies a query point d against the
// circumcircle of triangle a, b, c with an exact integer determinant and a
// scale-relative tolerance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------------
//  input     in         in_valid / in_stall       a_x a_y b_x b_y c_x c_y d_x d_y
//  result    out        out_valid / out_stall     side
//  config    in         cfg_we (no handshake)     cfg_wdata -> tolerance_scale
//
// One item enters per clock while in_stall is low and passes through the
// eight register stages; the sustained rate is one item per cycle unless stalled.
// Reset clears every valid bit and loads the tolerance scale with 1181.
// A stall on the result channel stops only the stages that are full behind
// it, so empty stages keep filling; the input is stalled only when all eight
// stages hold an item and the output is being held.
//
// Stage plan:
//   s1  differences from d
//   s2  squares, cross products, absolute differences
//   s3  squared lengths, 2x2 minors, scale m (largest magnitude, floor 1)
//   s4  split partial products of the three determinant terms, m^2
//   s5  determinant terms, m^2 * scale
//   s6  determinant, split partial products of m^4 * scale
//   s7  tolerance
//   s8  comparison and result register
//
module incircle_predicate_tolerant
	import icp_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] d_x,
	input  logic signed [COORD_WIDTH-1:0] d_y,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    side,

	input  logic                          cfg_we,
	input  logic [SCALE_W-1:0]            cfg_wdata
);

	// Differences lie strictly inside +/-2^W, so magnitudes fit in W bits.
	localparam int W      = COORD_WIDTH;
	localparam int D_W    = W + 1;           // signed difference
	localparam int PR_W   = 2 * D_W;         // signed product of two differences
	localparam int N_W    = 2 * W + 1;       // unsigned squared length
	localparam int K_W    = 2 * W + 2;       // signed 2x2 minor
	localparam int NL_W   = W + 1;           // low split of a squared length
	localparam int NH_W   = N_W - NL_W;      // high split of a squared length
	localparam int KL_W   = W + 1;           // low split of a minor (unsigned)
	localparam int KH_W   = K_W - KL_W;      // high split of a minor (signed)
	localparam int DET_W  = 4 * W + 5;       // signed determinant
	localparam int M2_W   = 2 * W;           // m^2
	localparam int Q_W    = M2_W + SCALE_W;  // m^2 * scale
	localparam int QL_W   = Q_W / 2;
	localparam int QH_W   = Q_W - QL_W;
	localparam int ML_W   = M2_W / 2;
	localparam int MH_W   = M2_W - ML_W;
	localparam int FULL_W = Q_W + M2_W;      // m^4 * scale
	localparam int SUM_W  = (FULL_W > TOL_SHIFT) ? FULL_W : TOL_SHIFT + 1;
	localparam int TOL_W  = SUM_W - TOL_SHIFT;
	localparam int CMP_W  = ((DET_W > TOL_W + 1) ? DET_W : TOL_W + 1) + 1;

	// ------------------------------------------------------------------
	// Configuration register. Writes must arrive only while the pipe is empty; the block does not enforce it.
	// ------------------------------------------------------------------
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Flow control. A stage loads when it is empty or when the stage
	// after it loads too, so bubbles are squeezed out under a stall.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	always_comb begin
		en8 = !valid_s8 || !out_stall;
		en7 = !valid_s7 || en8;
		en6 = !valid_s6 || en7;
		en5 = !valid_s5 || en6;
		en4 = !valid_s4 || en5;
		en3 = !valid_s3 || en4;
		en2 = !valid_s2 || en3;
		en1 = !valid_s1 || en2;
	end

	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
			if (en8) valid_s8 <= valid_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: differences from the query point.
	// Index order is ax, ay, bx, by, cx, cy.
	// ------------------------------------------------------------------
	logic signed [D_W-1:0] diff_s1 [6];

	always_ff @(posedge clk) begin
		if (en1) begin
			diff_s1[0] <= D_W'(a_x) - D_W'(d_x);
			diff_s1[1] <= D_W'(a_y) - D_W'(d_y);
			diff_s1[2] <= D_W'(b_x) - D_W'(d_x);
			diff_s1[3] <= D_W'(b_y) - D_W'(d_y);
			diff_s1[4] <= D_W'(c_x) - D_W'(d_x);
			diff_s1[5] <= D_W'(c_y) - D_W'(d_y);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squares, the six cross products of the minors, and the
	// magnitudes that feed the scale search.
	// Cross products are paired so that minor t is xp[2t] - xp[2t+1]:
	// minor 0 = bx*cy - by*cx, minor 1 = ax*cy - ay*cx, minor 2 = ax*by - ay*bx.
	// ------------------------------------------------------------------
	logic signed [PR_W-1:0] sq_s2  [6];
	logic signed [PR_W-1:0] xp_s2  [6];
	logic        [W-1:0]    mag_s2 [6];
	logic signed [D_W-1:0]  neg_c;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 6; i++) begin
				sq_s2[i] <= diff_s1[i] * diff_s1[i];
			end
			xp_s2[0] <= diff_s1[2] * diff_s1[5];
			xp_s2[1] <= diff_s1[3] * diff_s1[4];
			xp_s2[2] <= diff_s1[0] * diff_s1[5];
			xp_s2[3] <= diff_s1[1] * diff_s1[4];
			xp_s2[4] <= diff_s1[0] * diff_s1[3];
			xp_s2[5] <= diff_s1[1] * diff_s1[2];
		end
	end

	logic [W-1:0] mag_c [6];

	always_comb begin
		neg_c = '0;
		for (int i = 0; i < 6; i++) begin
			neg_c    = -diff_s1[i];
			mag_c[i] = diff_s1[i][D_W-1] ? neg_c[W-1:0] : diff_s1[i][W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			mag_s2 <= mag_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: squared lengths, minors and the scale m.
	// ------------------------------------------------------------------
	logic        [N_W-1:0] nsq_s3 [3];
	logic signed [K_W-1:0] k_s3   [3];
	logic        [W-1:0]   m_s3;
	logic        [W-1:0]   m_c;

	always_comb begin
		m_c = W'(1);
		for (int i = 0; i < 6; i++) begin
			if (mag_s2[i] > m_c) begin
				m_c = mag_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int t = 0; t < 3; t++) begin
				nsq_s3[t] <= sq_s2[2*t][N_W-1:0] + sq_s2[2*t+1][N_W-1:0];
				k_s3[t]   <= xp_s2[2*t] - xp_s2[2*t+1];
			end
			m_s3 <= m_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: each determinant term nsq * k is split into four narrow
	// partial products. The low half of k is unsigned, the high half
	// carries the sign.
	// ------------------------------------------------------------------
	logic        [NL_W+KL_W-1:0]   pll_s4 [3];
	logic signed [NL_W+KH_W:0]     plh_s4 [3];
	logic        [NH_W+KL_W-1:0]   phl_s4 [3];
	logic signed [NH_W+KH_W:0]     phh_s4 [3];
	logic        [M2_W-1:0]        m2_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int t = 0; t < 3; t++) begin
				pll_s4[t] <= nsq_s3[t][NL_W-1:0] * k_s3[t][KL_W-1:0];
				plh_s4[t] <= $signed({1'b0, nsq_s3[t][NL_W-1:0]})
				             * $signed(k_s3[t][K_W-1:KL_W]);
				phl_s4[t] <= nsq_s3[t][N_W-1:NL_W] * k_s3[t][KL_W-1:0];
				phh_s4[t] <= $signed({1'b0, nsq_s3[t][N_W-1:NL_W]})
				             * $signed(k_s3[t][K_W-1:KL_W]);
			end
			m2_s4 <= m_s3 * m_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: reassemble the three terms; start the tolerance product.
	// ------------------------------------------------------------------
	logic signed [DET_W-1:0] term_s5 [3];
	logic        [Q_W-1:0]   q_s5;
	logic        [M2_W-1:0]  m2_s5;
	logic signed [DET_W-1:0] term_c  [3];

	always_comb begin
		for (int t = 0; t < 3; t++) begin
			term_c[t] = DET_W'($signed({1'b0, pll_s4[t]}))
			          + (DET_W'(plh_s4[t]) <<< NL_W)
			          + (DET_W'($signed({1'b0, phl_s4[t]})) <<< KL_W)
			          + (DET_W'(phh_s4[t]) <<< (NL_W + KL_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			term_s5 <= term_c;
			q_s5    <= m2_s4 * scale_q;
			m2_s5   <= m2_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: determinant; split partial products of q * m^2.
	// ------------------------------------------------------------------
	logic signed [DET_W-1:0]     det_s6;
	logic        [QL_W+ML_W-1:0] tll_s6;
	logic        [QL_W+MH_W-1:0] tlh_s6;
	logic        [QH_W+ML_W-1:0] thl_s6;
	logic        [QH_W+MH_W-1:0] thh_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			det_s6 <= term_s5[0] - term_s5[1] + term_s5[2];
			tll_s6 <= q_s5[QL_W-1:0]   * m2_s5[ML_W-1:0];
			tlh_s6 <= q_s5[QL_W-1:0]   * m2_s5[M2_W-1:ML_W];
			thl_s6 <= q_s5[Q_W-1:QL_W] * m2_s5[ML_W-1:0];
			thh_s6 <= q_s5[Q_W-1:QL_W] * m2_s5[M2_W-1:ML_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: full m^4 * scale and the floored tolerance.
	// ------------------------------------------------------------------
	logic signed [DET_W-1:0] det_s7;
	logic        [TOL_W-1:0] tol_s7;
	logic        [SUM_W-1:0] full_c;

	always_comb begin
		full_c = SUM_W'(tll_s6)
		       + (SUM_W'(tlh_s6) << ML_W)
		       + (SUM_W'(thl_s6) << QL_W)
		       + (SUM_W'(thh_s6) << (QL_W + ML_W));
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			det_s7 <= det_s6;
			tol_s7 <= full_c[SUM_W-1:TOL_SHIFT];
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: classify against the symmetric tolerance band.
	// ------------------------------------------------------------------
	side_t                   side_s8;
	side_t                   side_c;
	logic signed [CMP_W-1:0] det_x;
	logic signed [CMP_W-1:0] tol_x;

	always_comb begin
		det_x = CMP_W'(det_s7);
		tol_x = $signed(CMP_W'(tol_s7));
		if (det_x > tol_x) begin
			side_c = SIDE_INSIDE;
		end else if (det_x < -tol_x) begin
			side_c = SIDE_OUTSIDE;
		end else begin
			side_c = SIDE_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			side_s8 <= side_c;
		end
	end

	assign out_valid = valid_s8;
	assign side      = side_s8;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The input is held off only when every stage is occupied and the
	// result is being held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 &&
		              valid_s5 && valid_s6 && valid_s7 && valid_s8 && out_stall))
		else $error("input stalled while the pipeline has a free stage");

	// An accepted item always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item did not reach the first stage");

	// A blocked item in front of the result register keeps its data.
	a_hold_s7: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !en8 |=> valid_s7 && $stable(det_s7) && $stable(tol_s7))
		else $error("stalled item changed or vanished before the result register");

	// A zero scale gives a strict sign test.
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && (scale_q == '0) |-> (tol_s7 == '0))
		else $error("nonzero tolerance with a zero scale");

endmodule
